// ===== rtl/sil_pkg.sv =====
package sil_pkg;

  // Widths of the item fields
  localparam int KEY_W    = 16;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;

  // Request modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_RECORD = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROP   = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                insert;
    logic                start_read;
    logic                rotate;
    logic                load_out;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } sil_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic rd_last;
  } sil_stat_t;

endpackage

// ===== rtl/sil_req_if.sv =====
interface sil_req_if import sil_pkg::*;;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key_value;
  logic [TAG_W-1:0] tag;

  modport source (output valid, output mode, output key_value, output tag, input ready);
  modport sink   (input valid, input mode, input key_value, input tag, output ready);
endinterface

// ===== rtl/sil_res_if.sv =====
interface sil_res_if import sil_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    key_out;
  logic [TAG_W-1:0]    tag_out;
  logic                last;

  modport source (output valid, output status, output key_out, output tag_out, output last,
                  input ready);
  modport sink   (input valid, input status, input key_out, input tag_out, input last,
                  output ready);
endinterface

// ===== rtl/sil_ctrl.sv =====
module sil_ctrl import sil_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_mode,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  sil_stat_t stat,
  output sil_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          if (in_mode == MODE_INSERT) begin
            if (stat.full) begin
              cmd.out_status = ST_DROP;
            end else begin
              cmd.insert     = 1'b1;
              cmd.out_status = ST_ACCEPT;
            end
          end else if (stat.empty) begin
            cmd.out_status = ST_EMPTY;
          end else begin
            cmd.load_out   = 1'b0;
            cmd.start_read = 1'b1;
            state_next     = S_READ;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          cmd.rotate     = 1'b1;
          cmd.out_status = ST_RECORD;
          cmd.out_last   = stat.rd_last;
          if (stat.rd_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !in_ready)
    else $error("request accepted during readout");

  a_read_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.rotate && stat.rd_last) |=> (state == S_IDLE))
    else $error("readout did not end after final record");

  a_result_not_lost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.load_out)
    else $error("result overwritten while waiting");
`endif

endmodule

// ===== rtl/sil_datapath.sv =====
module sil_datapath import sil_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  sil_cmd_t            cmd,
  output sil_stat_t           stat,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [TAG_W-1:0]    in_tag,
  output logic [STATUS_W-1:0] out_status,
  output logic [KEY_W-1:0]    out_key,
  output logic [TAG_W-1:0]    out_tag,
  output logic                out_last
);

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KW-1:0]    key_cell [CAPACITY];
  logic [TAG_W-1:0] tag_cell [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CW-1:0]    fill_count;
  logic [CW-1:0]    rd_cnt;
  logic [KW-1:0]    new_key;

  assign new_key      = KW'(in_key);
  assign stat.full    = (fill_count == CW'(CAPACITY));
  assign stat.empty   = (fill_count == '0);
  assign stat.rd_last = (rd_cnt == CW'(1));

  // Each cell compares against the new key and either holds, takes the new
  // record, or takes its lower neighbour; on readout the valid region rotates
  // towards cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    localparam logic [CW-1:0] NXT = CW'(i + 1);
    localparam int P = (i == 0) ? 0 : i - 1;
    localparam int J = (i == CAPACITY - 1) ? i : i + 1;

    logic prev_ge;
    logic is_pos;

    assign ge[i]   = (IDX < fill_count) && (key_cell[i] >= new_key);
    assign prev_ge = (i != 0) && ge[P];
    assign is_pos  = !prev_ge && (ge[i] || (IDX == fill_count));

    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (prev_ge) begin
          key_cell[i] <= key_cell[P];
          tag_cell[i] <= tag_cell[P];
        end else if (is_pos) begin
          key_cell[i] <= new_key;
          tag_cell[i] <= in_tag;
        end
      end else if (cmd.rotate) begin
        if (NXT < fill_count) begin
          key_cell[i] <= key_cell[J];
          tag_cell[i] <= tag_cell[J];
        end else if (NXT == fill_count) begin
          key_cell[i] <= key_cell[0];
          tag_cell[i] <= tag_cell[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rd_cnt     <= '0;
    end else begin
      if (cmd.insert) begin
        fill_count <= fill_count + CW'(1);
      end
      if (cmd.start_read) begin
        rd_cnt <= fill_count;
      end else if (cmd.rotate) begin
        rd_cnt <= rd_cnt - CW'(1);
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= cmd.out_status;
      out_last   <= cmd.out_last;
      if (cmd.out_status == ST_RECORD) begin
        out_key <= KEY_W'(key_cell[0]);
        out_tag <= tag_cell[0];
      end else begin
        out_key <= '0;
        out_tag <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> (fill_count == $past(fill_count) + CW'(1)) && (fill_count <= CW'(CAPACITY)))
    else $error("fill count out of step");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !stat.full)
    else $error("insert into full table");

  a_rotate_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rotate |-> (rd_cnt != '0) && (rd_cnt <= fill_count))
    else $error("rotate outside readout");
`endif

endmodule

// ===== rtl/sorted_insert_list.sv =====
// Sorted record table. Holds up to CAPACITY records of key and tag in
// ascending key order, in a chain of compare-and-shift cells. An insert
// request (mode 0) places its record ahead of every stored record with an
// equal or greater key, so the newest of equal keys comes first, and answers
// with one result: status 2 when stored, status 3 when the table is full and
// the record is dropped. A readout request (mode 1) streams every record from
// the lowest key up, one result per cycle, with last set on the final one, or
// answers status 1 once if the table is empty. Keys are kept to KEY_BITS bits
// (at most 16). An insert updates the whole cell chain at once, so inserts
// are accepted every cycle while results are taken; a readout of n records
// first loads the read count, then rotates one record out of the head cell
// per result, and no request is taken until its final record is loaded
// into the result register. Back-pressure on the result side stalls the
// readout and holds new requests. Contents after reset are empty; no clearing
// pass is needed.
module sorted_insert_list import sil_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  sil_req_if.sink   req,
  sil_res_if.source res
);

  sil_cmd_t  cmd;
  sil_stat_t stat;

  // Sequence requests: accept, drop, or step through a readout
  sil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_mode   (req.mode),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the cell chain, fill count and the result payload register
  sil_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_key     (req.key_value),
    .in_tag     (req.tag),
    .out_status (res.status),
    .out_key    (res.key_out),
    .out_tag    (res.tag_out),
    .out_last   (res.last)
  );

endmodule
